>>> rtl/pgvu_pkg.sv
// Shared types and constants for the packed grid value unpacker.
// Used by every module under rtl; it depends on nothing else.
package pgvu_pkg;

    // Default sizes handed down from the top level.
    localparam int BUFFER_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Widest packed value, in bits.
    localparam int MAX_VALUE_BITS = 32;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [2:0] REG_VALUE_BITS      = 3'd0;
    localparam logic [2:0] REG_SCALED_OFFSET   = 3'd1;
    localparam logic [2:0] REG_SCALE_MANTISSA  = 3'd2;
    localparam logic [2:0] REG_SCALE_SHIFT     = 3'd3;
    localparam logic [2:0] REG_PLAIN_REFERENCE = 3'd4;

    // Input commands.
    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Missing-value window: values that round to 9999 in Q40.24.
    localparam logic signed [63:0] SENTINEL_LO =
        64'sd9999 * 64'sd16777216 - 64'sd8388608;
    localparam logic signed [63:0] SENTINEL_HI = SENTINEL_LO + 64'sd16777216;

    typedef enum logic [2:0] {
        ST_VALUE    = 3'd0,
        ST_BITMAP   = 3'd1,
        ST_SENTINEL = 3'd2,
        ST_UNDER    = 3'd3,
        ST_OVER     = 3'd4
    } t_status;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       present;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] value;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic [5:0]         value_bits;
        logic signed [63:0] scaled_offset;
        logic [31:0]        scale_mantissa;
        logic signed [6:0]  scale_shift;
        logic signed [63:0] plain_reference;
    } t_cfg;

    // Work handed from the front end to the arithmetic back end. When decode
    // is set, payload carries the raw packed value (later the product, then
    // the scaled term); otherwise payload and status are the final result.
    typedef struct packed {
        logic        decode;
        t_status     status;
        logic [63:0] payload;
    } t_job;

endpackage

>>> rtl/pgvu_front.sv
// Front end: owns the bit buffer, classifies each accepted transaction and
// extracts the packed value. Depends on pgvu_pkg.
module pgvu_front
    import pgvu_pkg::*;
#(
    parameter int BUFFER_BITS = BUFFER_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job
);

    localparam int CW = $clog2(BUFFER_BITS + 1);

    logic [BUFFER_BITS-1:0] r_buf, n_buf;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [5:0]             w;
    logic [CW-1:0]          shift_down;
    logic [BUFFER_BITS-1:0] shifted;
    logic [MAX_VALUE_BITS-1:0] x_mask;

    assign w          = (i_cfg.value_bits > 6'(MAX_VALUE_BITS)) ?
                        6'(MAX_VALUE_BITS) : i_cfg.value_bits;
    assign shift_down = r_cnt - CW'(w);
    assign shifted    = r_buf >> shift_down;
    assign x_mask     = MAX_VALUE_BITS'(({{MAX_VALUE_BITS{1'b0}}, 1'b1} << w) - 1'b1);

    always_comb begin
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        o_job_valid = 1'b0;
        o_job       = '0;
        o_job.status = ST_VALUE;
        if (i_accept) begin
            priority if (i_item.command == CMD_PUSH) begin
                if ((32'(r_cnt) + 32'd8) > 32'(BUFFER_BITS)) begin
                    o_job_valid  = 1'b1;
                    o_job.status = ST_OVER;
                end else begin
                    n_buf = {r_buf[BUFFER_BITS-9:0], i_item.data_byte};
                    n_cnt = r_cnt + CW'(8);
                end
            end else if (!i_item.present) begin
                o_job_valid  = 1'b1;
                o_job.status = ST_BITMAP;
            end else if (w == 6'd0) begin
                o_job_valid   = 1'b1;
                o_job.payload = i_cfg.plain_reference;
            end else if (32'(r_cnt) < 32'(w)) begin
                o_job_valid  = 1'b1;
                o_job.status = ST_UNDER;
            end else begin
                o_job_valid   = 1'b1;
                o_job.decode  = 1'b1;
                o_job.payload = 64'(shifted[MAX_VALUE_BITS-1:0] & x_mask);
                n_cnt         = shift_down;
                n_buf         = r_buf & ~({BUFFER_BITS{1'b1}} << shift_down);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/pgvu_queue.sv
// Short first-in first-out queue of jobs between the front and back ends.
// Depends on pgvu_pkg.
module pgvu_queue
    import pgvu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

>>> rtl/pgvu_back.sv
// Back end: three-stage multiply, scale and saturating add with the missing
// value check; the last stage is the output register. Depends on pgvu_pkg.
module pgvu_back
    import pgvu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic r_v1, r_v2, r_v3;
    t_job r_job1, r_job2;
    t_out_item r_out;
    logic en1, en2, en3;

    logic [127:0]       wide;
    logic [6:0]         k_down;
    logic [64:0]        down;
    logic [63:0]        term;
    logic signed [66:0] sum;
    logic signed [63:0] y;
    t_job               n_job1, n_job2;
    t_out_item          n_out;

    // A stage moves when the one after it is empty or moving.
    assign en3   = !r_v3 || i_out_ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_job_valid && en1;

    // Stage 1: product of the packed value and the mantissa.
    always_comb begin
        n_job1 = i_job;
        if (i_job.decode) begin
            n_job1.payload = 64'(i_job.payload[31:0]) * 64'(i_cfg.scale_mantissa);
        end
    end

    // Stage 2: power-of-two scaling, saturating up and rounding half up down.
    always_comb begin
        wide   = 128'(r_job1.payload) << i_cfg.scale_shift[5:0];
        k_down = 7'(-i_cfg.scale_shift);
        down   = {r_job1.payload, 1'b0} >> k_down;
        if (i_cfg.scale_shift >= 0) begin
            term = (wide[127:64] != '0) ? {64{1'b1}} : wide[63:0];
        end else begin
            term = down[64:1] + 64'(down[0]);
        end
        n_job2 = r_job1;
        if (r_job1.decode) begin
            n_job2.payload = term;
        end
    end

    // Stage 3: saturating add of the offset and the missing-value window.
    always_comb begin
        sum = 67'(i_cfg.scaled_offset) + $signed({3'b000, r_job2.payload});
        if (sum > $signed({4'b0000, {63{1'b1}}})) begin
            y = {1'b0, {63{1'b1}}};
        end else begin
            y = sum[63:0];
        end
        if (r_job2.decode) begin
            if (y >= SENTINEL_LO && y < SENTINEL_HI) begin
                n_out.value  = '0;
                n_out.status = ST_SENTINEL;
            end else begin
                n_out.value  = y;
                n_out.status = ST_VALUE;
            end
        end else begin
            n_out.value  = r_job2.payload;
            n_out.status = r_job2.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_job1 <= n_job1;
        end
        if (en2) begin
            r_job2 <= n_job2;
        end
        if (en3) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_job_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

endmodule

>>> rtl/packed_grid_value_unpacker_top.sv
// Top level of the packed grid value unpacker: configuration registers,
// front end, job queue and arithmetic back end. Depends on pgvu_pkg.
//
// This block decodes simple-packed grid data as a stream. A transaction with
// command push shifts one data byte, most significant bit first, into a bit
// buffer of BUFFER_BITS bits; it returns nothing unless the buffer has no room,
// in which case the byte is dropped and an overflow result is returned. A
// transaction with command decode returns exactly one result: bitmap missing
// when the point is absent, the plain reference when the bit width is zero,
// underflow when too few bits are buffered (nothing is consumed), and
// otherwise offset plus X times mantissa times two to the shift, in Q40.24
// and saturated to the signed 64-bit range, reported as sentinel missing when
// it rounds to 9999. The block takes one transaction per clock cycle while its
// job queue has room. The front end classifies each transaction and updates
// the bit buffer in the cycle it is accepted; each result then passes through
// the registered job queue and the multiply, scale and add stages of the back
// end. A queue of QUEUE_DEPTH jobs sits between the two, so input is taken
// while results wait at the output, and input ready drops only when that queue
// is full. Registers are written over the APB-style port at byte address 8
// times the register index and should only be changed while the block is idle.
module packed_grid_value_unpacker_top
    import pgvu_pkg::*;
#(
    parameter int BUFFER_BITS = BUFFER_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // Result transactions.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_write;

    logic in_accept;
    logic front_job_valid;
    t_job front_job;
    logic q_valid, q_full, q_pop;
    t_job q_job;

    // Register file. Writes land at the access phase; reads are combinational.
    assign reg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_VALUE_BITS:      r_cfg.value_bits      <= pwdata[5:0];
                REG_SCALED_OFFSET:   r_cfg.scaled_offset   <= pwdata;
                REG_SCALE_MANTISSA:  r_cfg.scale_mantissa  <= pwdata[31:0];
                REG_SCALE_SHIFT:     r_cfg.scale_shift     <= pwdata[6:0];
                REG_PLAIN_REFERENCE: r_cfg.plain_reference <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VALUE_BITS:      prdata = 64'(r_cfg.value_bits);
            REG_SCALED_OFFSET:   prdata = r_cfg.scaled_offset;
            REG_SCALE_MANTISSA:  prdata = 64'(r_cfg.scale_mantissa);
            REG_SCALE_SHIFT:     prdata = 64'(r_cfg.scale_shift);
            REG_PLAIN_REFERENCE: prdata = r_cfg.plain_reference;
            default:             prdata = '0;
        endcase
    end

    // The front end takes a transaction whenever the queue has room for the
    // job it might create.
    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    pgvu_front #(
        .BUFFER_BITS(BUFFER_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .o_job_valid (front_job_valid),
        .o_job       (front_job)
    );

    pgvu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_job_valid),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    pgvu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/pgvu_checker.sv
// Port-level checks for the packed grid value unpacker, bound to the top level.
// Depends on pgvu_pkg and packed_grid_value_unpacker_top.
module pgvu_checker
    import pgvu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data,
    input logic      pready
);

    // Any status other than a plain value carries a zero value.
    a_zero_when_not_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_VALUE |-> o_out_data.value == '0)
        else $error("non-value result carries a nonzero value");

    // A stalled result stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // The configuration port never inserts wait states.
    a_pready_high: assert property (@(posedge i_clk) pready)
        else $error("pready went low");

    // No result is shown in the cycle after a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind packed_grid_value_unpacker_top pgvu_checker u_pgvu_checker (.*);
